// File: sv/assert_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/srfr_pkg.sv
// Types and constants of the serial response frame receiver.
`timescale 1ns / 1ps
package srfr_pkg;

  localparam logic [7:0] START_CODE    = 8'h70;
  localparam logic [7:0] END_CODE      = 8'h0A;
  localparam logic [7:0] FLAG_OK       = 8'h61;
  localparam logic [7:0] CMD_IDENTIFY  = 8'h2F;
  localparam logic [7:0] CMD_CLEAR_ALL = 8'h27;
  // Position of the end code, the last byte of a 13-byte frame
  localparam logic [3:0] LAST_POS      = 4'd12;
  // Last position that enters the checksum
  localparam logic [3:0] SUM_LAST_POS  = 4'd10;

  typedef enum logic {
    MODE_BYTE    = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_HUNTING  = 3'd1,
    ST_BUSY     = 3'd2,
    ST_END_ERR  = 3'd3,
    ST_SUM_ERR  = 3'd4,
    ST_COMPLETE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    MSG_NONE        = 3'd0,
    MSG_VERIFY_OK   = 3'd1,
    MSG_VERIFY_FAIL = 3'd2,
    MSG_CLEAR_OK    = 3'd3,
    MSG_CLEAR_FAIL  = 3'd4
  } message_t;

  // Receiver state carried from one request to the next
  typedef struct packed {
    logic [3:0]  byte_count;
    logic [7:0]  running_sum;
    logic        frame_held;
    logic [7:0]  held_command;
    logic [31:0] held_param;
    logic [31:0] held_size;
    logic [7:0]  held_flag;
    logic [7:0]  held_checksum;
  } rx_state_t;

  // One result request
  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [31:0] param_word;
    logic [31:0] size_word;
    logic [7:0]  flag_byte;
    message_t    message;
    logic [31:0] event_id;
  } result_t;

endpackage

// File: sv/srfr_step.sv
// Per-byte frame assembly, checksum check and classification.
`timescale 1ns / 1ps
module srfr_step (
  input  srfr_pkg::rx_state_t st,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic                tx_active,
  output srfr_pkg::rx_state_t st_next,
  output srfr_pkg::result_t   res
);

  logic [3:0] pos;
  logic [7:0] sum_next;

  always_comb begin
    st_next  = st;
    pos      = st.byte_count;
    sum_next = st.running_sum;
    res.status   = srfr_pkg::ST_ACCEPTED;
    res.message  = srfr_pkg::MSG_NONE;
    res.event_id = 32'd0;

    if (mode == srfr_pkg::MODE_RELEASE) begin
      // release: drop held frame and any partial frame
      st_next.byte_count  = 4'd0;
      st_next.running_sum = 8'd0;
      st_next.frame_held  = 1'b0;
    end else if (st.frame_held && tx_active) begin
      res.status = srfr_pkg::ST_BUSY;
    end else begin
      // a byte while held drops the held frame and starts a hunt
      if (st.frame_held) begin
        st_next.byte_count  = 4'd0;
        st_next.running_sum = 8'd0;
        st_next.frame_held  = 1'b0;
        pos = 4'd0;
      end
      sum_next = st_next.running_sum;

      if (pos == 4'd0 && data_byte != srfr_pkg::START_CODE) begin
        res.status = srfr_pkg::ST_HUNTING;
      end else begin
        // start code clears the held fields
        if (pos == 4'd0) begin
          st_next.held_command  = 8'd0;
          st_next.held_param    = 32'd0;
          st_next.held_size     = 32'd0;
          st_next.held_flag     = 8'd0;
          st_next.held_checksum = 8'd0;
        end
        if (pos <= srfr_pkg::SUM_LAST_POS) begin
          sum_next = st_next.running_sum + data_byte;
        end
        st_next.running_sum = sum_next;

        // byte lane write by frame position
        unique case (pos)
          4'd1:    st_next.held_command      = data_byte;
          4'd2:    st_next.held_param[7:0]   = data_byte;
          4'd3:    st_next.held_param[15:8]  = data_byte;
          4'd4:    st_next.held_param[23:16] = data_byte;
          4'd5:    st_next.held_param[31:24] = data_byte;
          4'd6:    st_next.held_size[7:0]    = data_byte;
          4'd7:    st_next.held_size[15:8]   = data_byte;
          4'd8:    st_next.held_size[23:16]  = data_byte;
          4'd9:    st_next.held_size[31:24]  = data_byte;
          4'd10:   st_next.held_flag         = data_byte;
          4'd11:   st_next.held_checksum     = data_byte;
          default: ;
        endcase

        // end of frame: end code first, then checksum
        if (pos >= srfr_pkg::LAST_POS) begin
          st_next.byte_count  = 4'd0;
          st_next.running_sum = 8'd0;
          st_next.frame_held  = 1'b0;
          if (data_byte != srfr_pkg::END_CODE) begin
            res.status = srfr_pkg::ST_END_ERR;
          end else if (st_next.held_checksum != sum_next) begin
            res.status = srfr_pkg::ST_SUM_ERR;
          end else begin
            res.status = srfr_pkg::ST_COMPLETE;
            if (st_next.held_command == srfr_pkg::CMD_IDENTIFY) begin
              res.message  = (st_next.held_flag == srfr_pkg::FLAG_OK) ?
                             srfr_pkg::MSG_VERIFY_OK : srfr_pkg::MSG_VERIFY_FAIL;
              res.event_id = st_next.held_param;
            end else if (st_next.held_command == srfr_pkg::CMD_CLEAR_ALL) begin
              res.message = (st_next.held_flag == srfr_pkg::FLAG_OK) ?
                            srfr_pkg::MSG_CLEAR_OK : srfr_pkg::MSG_CLEAR_FAIL;
            end else begin
              st_next.frame_held = 1'b1;
            end
          end
        end else begin
          st_next.byte_count = pos + 4'd1;
        end
      end
    end

    res.command    = st_next.held_command;
    res.param_word = st_next.held_param;
    res.size_word  = st_next.held_size;
    res.flag_byte  = st_next.held_flag;
  end

endmodule

// File: sv/serial_response_frame_receiver.sv
// Requests pass via the input register and the step to the result register on m_*.
// Throughput: one request per cycle while m_tready does not stall the output; the input
// register refills in the cycle it hands its request to the result register.
// All state updates in the single combinational step between the two registers.
// Reset (rst, synchronous, active high) empties both registers and clears the
// frame counter, checksum, held flag and held frame fields.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serial_response_frame_receiver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [7:0] data_byte, [8] tx_active, [15:9] zero
  input  logic         s_tuser,   // [0] mode
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] command, [39:8] param_word, [71:40] size_word, [79:72] flag_byte,
  // [82:80] message, [114:83] event_id, [119:115] zero
  output logic [119:0] m_tdata,
  output logic [2:0]   m_tuser    // [2:0] status
);

  logic                in_valid;
  logic                in_mode;
  logic [7:0]          in_byte;
  logic                in_tx;
  srfr_pkg::rx_state_t st;
  srfr_pkg::rx_state_t st_next;
  srfr_pkg::result_t   res;
  srfr_pkg::result_t   out_res;
  logic                out_valid;
  logic                advance;

  // input register moves on when the result register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata[7:0];
      in_tx   <= s_tdata[8];
    end
  end

  srfr_step u_step (
    .st        (st),
    .mode      (in_mode),
    .data_byte (in_byte),
    .tx_active (in_tx),
    .st_next   (st_next),
    .res       (res)
  );

  // receiver state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {5'd0, out_res.event_id, out_res.message, out_res.flag_byte,
                     out_res.size_word, out_res.param_word, out_res.command};

  // checks
  `ASSERT_ALWAYS(a_count_range, clk, rst, st.byte_count <= srfr_pkg::LAST_POS)
  `ASSERT_IMPLY(a_held_idle, clk, rst, st.frame_held, st.byte_count == 4'd0)
  `ASSERT_IMPLY(a_sum_idle, clk, rst, st.byte_count == 4'd0, st.running_sum == 8'd0)
  `ASSERT_IMPLY(a_msg_complete, clk, rst, out_valid && out_res.message != srfr_pkg::MSG_NONE, out_res.status == srfr_pkg::ST_COMPLETE)

endmodule

// File: test/serial_response_frame_receiver_test.sv
// Testbench of the serial response frame receiver: directed table, random frames, checked results.
`timescale 1ns / 1ps
module serial_response_frame_receiver_test;
  import srfr_pkg::*;

  localparam logic [7:0] FLAG_FAIL = 8'h63;
  localparam int FRAME_BYTES = 13;

  typedef enum logic [1:0] {
    RQ_BYTE    = 2'd0,
    RQ_RELEASE = 2'd1,
    RQ_FRAME   = 2'd2
  } rq_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_END  = 2'd1,
    FAULT_SUM  = 2'd2
  } fault_e;

  // One line of the directed table; a frame row expands to 13 byte requests
  typedef struct packed {
    rq_kind_e    kind;
    logic [7:0]  data;         // byte, or command of a frame
    logic        tx;
    logic [31:0] param;
    logic [31:0] size;
    logic [7:0]  flag;
    fault_e      fault;
    logic        chk;          // typed status and message below apply
    status_t     exp_status;   // for a frame: status of its end byte
    message_t    exp_message;
  } stim_row_t;

  localparam int DIR_ROWS = 17;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // hunting after reset, extremes of the byte
    '{RQ_BYTE, 8'h00, 1'b0, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_HUNTING, MSG_NONE},
    '{RQ_BYTE, 8'hFF, 1'b1, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_HUNTING, MSG_NONE},
    '{RQ_RELEASE, 8'hFF, 1'b1, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_ACCEPTED, MSG_NONE},
    // ordinary frame is held, then busy, then dropped by a byte outside transmit
    '{RQ_FRAME, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0, 8'h00, FAULT_NONE, 1'b1,
      ST_COMPLETE, MSG_NONE},
    '{RQ_BYTE, 8'h70, 1'b1, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_BUSY, MSG_NONE},
    '{RQ_BYTE, 8'hFF, 1'b0, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_HUNTING, MSG_NONE},
    // bad end code, then unsolicited identify and clear-all responses
    '{RQ_FRAME, 8'hFF, 1'b1, 32'h0, 32'hFFFF_FFFF, 8'hFF, FAULT_END, 1'b1,
      ST_END_ERR, MSG_NONE},
    '{RQ_FRAME, CMD_IDENTIFY, 1'b0, 32'h1234_5678, 32'h0, FLAG_OK, FAULT_NONE, 1'b1,
      ST_COMPLETE, MSG_VERIFY_OK},
    '{RQ_FRAME, CMD_IDENTIFY, 1'b1, 32'h8000_0001, 32'h1, FLAG_FAIL, FAULT_NONE, 1'b1,
      ST_COMPLETE, MSG_VERIFY_FAIL},
    '{RQ_FRAME, CMD_CLEAR_ALL, 1'b0, 32'h0, 32'h0, FLAG_OK, FAULT_NONE, 1'b1,
      ST_COMPLETE, MSG_CLEAR_OK},
    '{RQ_FRAME, CMD_CLEAR_ALL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, FAULT_NONE, 1'b1,
      ST_COMPLETE, MSG_CLEAR_FAIL},
    // bad checksum
    '{RQ_FRAME, 8'h55, 1'b0, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 8'h61, FAULT_SUM, 1'b1,
      ST_SUM_ERR, MSG_NONE},
    // release in the middle of a frame
    '{RQ_BYTE, 8'h70, 1'b0, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b0, ST_ACCEPTED, MSG_NONE},
    '{RQ_RELEASE, 8'h00, 1'b0, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_ACCEPTED, MSG_NONE},
    '{RQ_FRAME, 8'h10, 1'b1, 32'hDEAD_BEEF, 32'h0000_0100, 8'h7E, FAULT_NONE, 1'b0,
      ST_COMPLETE, MSG_NONE},
    '{RQ_RELEASE, 8'h70, 1'b1, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_ACCEPTED, MSG_NONE},
    // transmit flag has no effect when nothing is held
    '{RQ_BYTE, 8'h70, 1'b1, 32'h0, 32'h0, 8'h00, FAULT_NONE, 1'b1, ST_ACCEPTED, MSG_NONE}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [2:0]   m_tuser;

  serial_response_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("[serial_response_frame_receiver] ERROR");
    $finish;
  end

  rx_state_t rx_st;
  result_t   result_q[$];
  int        n_errors = 0;
  int        n_counted = 0;
  int        gap_odds = 4;     // 0: no sender gaps
  int        stall_odds = 4;   // 0: no receiver stalls
  int        stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void rx_restart();
    rx_st.byte_count  = '0;
    rx_st.running_sum = '0;
    rx_st.frame_held  = 1'b0;
  endfunction

  function automatic result_t rx_step(input mode_t mode, input logic [7:0] b, input logic tx);
    result_t     r;
    int unsigned p;
    r.status   = ST_ACCEPTED;
    r.message  = MSG_NONE;
    r.event_id = '0;
    if (mode == MODE_RELEASE) begin
      rx_restart();
    end else if (rx_st.frame_held && tx) begin
      r.status = ST_BUSY;
    end else begin
      if (rx_st.frame_held) rx_restart();
      p = rx_st.byte_count;
      if (p == 0 && b != START_CODE) begin
        r.status = ST_HUNTING;
      end else begin
        // start code opens a fresh frame
        if (p == 0) begin
          rx_st.held_command  = '0;
          rx_st.held_param    = '0;
          rx_st.held_size     = '0;
          rx_st.held_flag     = '0;
          rx_st.held_checksum = '0;
        end
        if (p <= SUM_LAST_POS) rx_st.running_sum = rx_st.running_sum + b;
        if (p == 1) rx_st.held_command = b;
        else if (p >= 2 && p <= 5) rx_st.held_param[8*(p-2) +: 8] = b;
        else if (p >= 6 && p <= 9) rx_st.held_size[8*(p-6) +: 8] = b;
        else if (p == SUM_LAST_POS) rx_st.held_flag = b;
        else if (p == SUM_LAST_POS + 1) rx_st.held_checksum = b;

        if (p == LAST_POS) begin
          if (b != END_CODE) begin
            r.status = ST_END_ERR;
            rx_restart();
          end else if (rx_st.held_checksum != rx_st.running_sum) begin
            r.status = ST_SUM_ERR;
            rx_restart();
          end else begin
            r.status          = ST_COMPLETE;
            rx_st.byte_count  = '0;
            rx_st.running_sum = '0;
            rx_st.frame_held  = 1'b1;
            // unsolicited responses are released at once
            if (rx_st.held_command == CMD_IDENTIFY) begin
              r.message  = (rx_st.held_flag == FLAG_OK) ? MSG_VERIFY_OK : MSG_VERIFY_FAIL;
              r.event_id = rx_st.held_param;
              rx_restart();
            end else if (rx_st.held_command == CMD_CLEAR_ALL) begin
              r.message = (rx_st.held_flag == FLAG_OK) ? MSG_CLEAR_OK : MSG_CLEAR_FAIL;
              rx_restart();
            end
          end
        end else begin
          rx_st.byte_count = 4'(p + 1);
        end
      end
    end
    r.command    = rx_st.held_command;
    r.param_word = rx_st.held_param;
    r.size_word  = rx_st.held_size;
    r.flag_byte  = rx_st.held_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_req(input mode_t mode, input logic [7:0] b, input logic tx,
                          input logic chk, input status_t exp_st, input message_t exp_msg);
    result_t r;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, tx, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = rx_step(mode, b, tx);
    if (chk) begin
      r.status  = exp_st;
      r.message = exp_msg;
    end
    result_q.push_back(r);
    if (r.status != ST_HUNTING) n_counted++;
  endtask

  // Builds a frame, optionally broken, and sends its first nbytes bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [31:0] param,
                            input logic [31:0] size, input logic [7:0] flag,
                            input fault_e fault, input logic tx, input int nbytes,
                            input logic chk, input status_t exp_st, input message_t exp_msg);
    logic [7:0] fr [FRAME_BYTES];
    logic [7:0] sum;
    fr[0]  = START_CODE;
    fr[1]  = cmd;
    fr[10] = flag;
    for (int i = 0; i < 4; i++) begin
      fr[2+i] = param[8*i +: 8];
      fr[6+i] = size[8*i +: 8];
    end
    sum = '0;
    for (int i = 0; i <= SUM_LAST_POS; i++) sum = sum + fr[i];
    fr[11] = (fault == FAULT_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    fr[12] = (fault == FAULT_END) ? END_CODE ^ 8'($urandom_range(1, 255)) : END_CODE;
    for (int i = 0; i < nbytes; i++)
      send_req(MODE_BYTE, fr[i], tx, chk && i == FRAME_BYTES - 1, exp_st, exp_msg);
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 6;
      default: return 20;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result status", 32'(m_tuser), 32'(0));
      end else begin
        want = result_q.pop_front();
        if (m_tuser != want.status)
          report_mismatch("status", 32'(m_tuser), 32'(want.status));
        if (m_tdata[7:0] != want.command)
          report_mismatch("command", 32'(m_tdata[7:0]), 32'(want.command));
        if (m_tdata[39:8] != want.param_word)
          report_mismatch("param_word", m_tdata[39:8], want.param_word);
        if (m_tdata[71:40] != want.size_word)
          report_mismatch("size_word", m_tdata[71:40], want.size_word);
        if (m_tdata[79:72] != want.flag_byte)
          report_mismatch("flag_byte", 32'(m_tdata[79:72]), 32'(want.flag_byte));
        if (m_tdata[82:80] != want.message)
          report_mismatch("message", 32'(m_tdata[82:80]), 32'(want.message));
        if (m_tdata[114:83] != want.event_id)
          report_mismatch("event_id", m_tdata[114:83], want.event_id);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t  row;
    int         seg_end;
    int         pick;
    logic [7:0] cmd;
    logic [7:0] flag;
    fault_e     fault;

    rx_st = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      case (row.kind)
        RQ_BYTE:
          send_req(MODE_BYTE, row.data, row.tx, row.chk, row.exp_status, row.exp_message);
        RQ_RELEASE:
          send_req(MODE_RELEASE, row.data, row.tx, row.chk, row.exp_status, row.exp_message);
        default:
          send_frame(row.data, row.param, row.size, row.flag, row.fault, row.tx,
                     FRAME_BYTES, row.chk, row.exp_status, row.exp_message);
      endcase
    end
    wait_drained();

    // random part: mostly well-formed frames, some noise and broken frames
    n_counted = 0;
    seg_end   = 0;
    while (n_counted < 1000) begin
      if (n_counted >= seg_end) begin
        seg_end   += 150;
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end
      if (n_counted >= 850) begin
        gap_odds   = 0;
        stall_odds = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_IDENTIFY;
          1:       cmd = CMD_CLEAR_ALL;
          default: cmd = 8'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0:       flag = FLAG_OK;
          1:       flag = FLAG_FAIL;
          default: flag = 8'($urandom());
        endcase
        case ($urandom_range(0, 9))
          0:       fault = FAULT_END;
          1:       fault = FAULT_SUM;
          default: fault = FAULT_NONE;
        endcase
        // truncated frames leave the receiver mid-frame for what follows
        send_frame(cmd, pick_word(), pick_word(), flag, fault, 1'($urandom()),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_BYTES - 1)
                                               : FRAME_BYTES,
                   1'b0, ST_ACCEPTED, MSG_NONE);
      end else if (pick < 82) begin
        send_req(MODE_BYTE, ($urandom_range(0, 3) == 0) ? START_CODE : 8'($urandom()),
                 1'($urandom()), 1'b0, ST_ACCEPTED, MSG_NONE);
      end else if (pick < 90) begin
        send_req(MODE_RELEASE, 8'($urandom()), 1'($urandom()), 1'b0, ST_ACCEPTED, MSG_NONE);
      end else if (pick < 98) begin
        // busy attempt when a frame is held
        send_req(MODE_BYTE, 8'($urandom()), 1'b1, 1'b0, ST_ACCEPTED, MSG_NONE);
      end else begin
        wait_drained();
      end
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[serial_response_frame_receiver] OK");
    end else begin
      $display("[serial_response_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/srfr_pkg.sv
sv/srfr_step.sv
sv/serial_response_frame_receiver.sv
test/serial_response_frame_receiver_test.sv
